@@ sv/quad_code_frame_and_circle_test_unit_defines.svh @@
// Assertion macros shared by the quad code frame and circle test RTL.
`ifndef QUAD_CODE_FRAME_AND_CIRCLE_TEST_UNIT_DEFINES_SVH
`define QUAD_CODE_FRAME_AND_CIRCLE_TEST_UNIT_DEFINES_SVH

// Same-cycle implication, checked on aclk outside of reset.
`define QCF_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on aclk outside of reset.
`define QCF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/qcf_pkg.sv @@
// Types and constants of the quad code frame and circle test.
package qcf_pkg;

    localparam int COORD_W        = 24;
    localparam int DIFF_W         = COORD_W + 1;
    localparam int SUM_W          = COORD_W + 2;
    localparam int PROD_W         = DIFF_W + SUM_W;
    localparam int SQ_W           = 2 * COORD_W;
    localparam int SCALE_W        = 2 * COORD_W + 1;
    localparam int NUM_W          = PROD_W + 1;
    localparam int MAG_W          = NUM_W - 1;
    localparam int INT_BITS       = 4;
    localparam int CODE_FRAC_BITS = 16;
    localparam int QUO_W          = CODE_FRAC_BITS + INT_BITS + 1;
    localparam int CODE_W         = 21;
    localparam int XS_W           = CODE_W + 1;
    localparam int XSQ_W          = 2 * CODE_W - 1;
    localparam int LHS_W          = XSQ_W + 5;
    localparam int TOL_W          = 16;
    localparam int SQRT2_FRAC     = 30;
    localparam int BOUND_FRAC     = 46;
    localparam int TOL_ALIGN      = SQRT2_FRAC - TOL_W;
    localparam int BOUND_SHIFT    = BOUND_FRAC - 2 * CODE_FRAC_BITS;
    localparam int BSUM_W         = SQRT2_FRAC + 2;
    localparam int RHS_W          = BSUM_W + TOL_W;
    localparam int RHSQ_W         = RHS_W - BOUND_SHIFT;
    localparam int CFG_W          = SCALE_W;
    localparam int CFG_IDX_W      = 2;
    localparam int IN_TDATA_W     = 6 * COORD_W;
    localparam int OUT_DATA_BITS  = SCALE_W + 2 * CODE_W;
    localparam int OUT_TDATA_W    = ((OUT_DATA_BITS + 7) / 8) * 8;
    localparam int OUT_TUSER_W    = 2;

    localparam logic [BSUM_W-1:0] SQRT2_Q30 = BSUM_W'(64'd1518500250);
    localparam logic [SCALE_W-1:0] MAX_SCALE_RESET = '1;
    localparam logic [TOL_W-1:0]   TOL_RESET       = TOL_W'(16'd655);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MIN_SCALE = 2'd0,
        REG_MAX_SCALE = 2'd1,
        REG_CODE_TOL  = 2'd2
    } cfg_idx_t;

    // Word handed from cell to cell along the divider row.
    typedef struct packed {
        logic [SCALE_W-1:0]  scale;
        logic                ok;
        logic                go;
        logic                neg_x;
        logic                neg_y;
        logic [SCALE_W-1:0]  rem_x;
        logic [SCALE_W-1:0]  rem_y;
        logic [INT_BITS-1:0] num_x;
        logic [INT_BITS-1:0] num_y;
        logic [QUO_W-1:0]    quo_x;
        logic [QUO_W-1:0]    quo_y;
    } div_t;

    typedef struct packed {
        logic [SCALE_W-1:0]       scale;
        logic                     scale_pass;
        logic                     in_circle;
        logic signed [CODE_W-1:0] code_x;
        logic signed [CODE_W-1:0] code_y;
    } res_t;

endpackage

@@ sv/qcf_front.sv @@
// Front end: differences, products, squared distance and the scale checks.
module qcf_front (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   en,
    input  logic                                   in_vld,
    input  logic [qcf_pkg::COORD_W-1:0]            a_x,
    input  logic [qcf_pkg::COORD_W-1:0]            a_y,
    input  logic [qcf_pkg::COORD_W-1:0]            b_x,
    input  logic [qcf_pkg::COORD_W-1:0]            b_y,
    input  logic [qcf_pkg::COORD_W-1:0]            c_x,
    input  logic [qcf_pkg::COORD_W-1:0]            c_y,
    input  logic [qcf_pkg::SCALE_W-1:0]            min_scale_sq,
    input  logic [qcf_pkg::SCALE_W-1:0]            max_scale_sq,
    output logic                                   out_vld,
    output qcf_pkg::div_t                          out_data
);
    import qcf_pkg::*;

    logic [3:0] vld_reg;

    logic signed [DIFF_W-1:0] dx_reg, dy_reg, cx_reg, cy_reg;
    logic signed [SUM_W-1:0]  p_reg, m_reg;
    logic signed [DIFF_W-1:0] dx_next, dy_next, cx_next, cy_next;

    logic [SQ_W-1:0]          dxx_reg, dyy_reg;
    logic signed [PROD_W-1:0] cxp_reg, cym_reg, cyp_reg, cxm_reg;

    logic [SCALE_W-1:0]       scale_reg;
    logic signed [NUM_W-1:0]  nx_reg, ny_reg;

    logic [MAG_W-1:0]         mag_x, mag_y;
    logic [MAG_W+1:0]         lim;
    logic                     ok;
    div_t                     div_next, div_reg;

    always_comb begin
        dx_next = $signed({1'b0, b_x}) - $signed({1'b0, a_x});
        dy_next = $signed({1'b0, b_y}) - $signed({1'b0, a_y});
        cx_next = $signed({1'b0, c_x}) - $signed({1'b0, a_x});
        cy_next = $signed({1'b0, c_y}) - $signed({1'b0, a_y});
    end

    always_comb begin
        mag_x = nx_reg[NUM_W-1] ? MAG_W'(-nx_reg) : MAG_W'(nx_reg);
        mag_y = ny_reg[NUM_W-1] ? MAG_W'(-ny_reg) : MAG_W'(ny_reg);
        lim   = (MAG_W+2)'({scale_reg, {INT_BITS{1'b0}}});
        ok    = (scale_reg != '0) && (scale_reg >= min_scale_sq)
                && (scale_reg <= max_scale_sq);
        div_next       = '0;
        div_next.scale = scale_reg;
        div_next.ok    = ok;
        div_next.go    = ok && ((MAG_W+2)'(mag_x) < lim) && ((MAG_W+2)'(mag_y) < lim);
        div_next.neg_x = nx_reg[NUM_W-1];
        div_next.neg_y = ny_reg[NUM_W-1];
        // Integer part starts with the numerator over 16; its low bits feed the cells.
        div_next.rem_x = SCALE_W'(mag_x >> INT_BITS);
        div_next.rem_y = SCALE_W'(mag_y >> INT_BITS);
        div_next.num_x = mag_x[INT_BITS-1:0];
        div_next.num_y = mag_y[INT_BITS-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[2:0], in_vld};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            dx_reg    <= dx_next;
            dy_reg    <= dy_next;
            cx_reg    <= cx_next;
            cy_reg    <= cy_next;
            p_reg     <= SUM_W'(dx_next) + SUM_W'(dy_next);
            m_reg     <= SUM_W'(dy_next) - SUM_W'(dx_next);
            dxx_reg   <= SQ_W'(dx_reg) * SQ_W'(dx_reg);
            dyy_reg   <= SQ_W'(dy_reg) * SQ_W'(dy_reg);
            cxp_reg   <= PROD_W'(cx_reg) * PROD_W'(p_reg);
            cym_reg   <= PROD_W'(cy_reg) * PROD_W'(m_reg);
            cyp_reg   <= PROD_W'(cy_reg) * PROD_W'(p_reg);
            cxm_reg   <= PROD_W'(cx_reg) * PROD_W'(m_reg);
            scale_reg <= SCALE_W'(dxx_reg) + SCALE_W'(dyy_reg);
            nx_reg    <= NUM_W'(cxp_reg) + NUM_W'(cym_reg);
            ny_reg    <= NUM_W'(cyp_reg) - NUM_W'(cxm_reg);
            div_reg   <= div_next;
        end
    end

    assign out_vld  = vld_reg[3];
    assign out_data = div_reg;

endmodule

@@ sv/qcf_div_cell.sv @@
// One cell of the divider row: one quotient bit for x and for y.
module qcf_div_cell (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          en,
    input  logic          in_vld,
    input  qcf_pkg::div_t in_data,
    output logic          out_vld,
    output qcf_pkg::div_t out_data
);
    import qcf_pkg::*;

    logic [SCALE_W:0] tx, ty, den;
    logic             ge_x, ge_y;
    div_t             data_next, data_reg;
    logic             vld_reg;

    always_comb begin
        den  = {1'b0, in_data.scale};
        tx   = {in_data.rem_x, in_data.num_x[INT_BITS-1]};
        ty   = {in_data.rem_y, in_data.num_y[INT_BITS-1]};
        ge_x = tx >= den;
        ge_y = ty >= den;
        data_next       = in_data;
        data_next.rem_x = ge_x ? SCALE_W'(tx - den) : tx[SCALE_W-1:0];
        data_next.rem_y = ge_y ? SCALE_W'(ty - den) : ty[SCALE_W-1:0];
        data_next.num_x = {in_data.num_x[INT_BITS-2:0], 1'b0};
        data_next.num_y = {in_data.num_y[INT_BITS-2:0], 1'b0};
        data_next.quo_x = {in_data.quo_x[QUO_W-2:0], ge_x};
        data_next.quo_y = {in_data.quo_y[QUO_W-2:0], ge_y};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else if (en) begin
            vld_reg <= in_vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            data_reg <= data_next;
        end
    end

    assign out_vld  = vld_reg;
    assign out_data = data_reg;

endmodule

@@ sv/qcf_back.sv @@
// Back end: rounding, squares, circle test and the output register.
module qcf_back (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        en,
    input  logic                        in_vld,
    input  qcf_pkg::div_t               in_data,
    input  logic [qcf_pkg::RHSQ_W-1:0]  bound,
    output logic                        out_vld,
    output qcf_pkg::res_t               out_data
);
    import qcf_pkg::*;

    logic [2:0] vld_reg;

    logic [QUO_W:0]          rnd_x, rnd_y;
    logic [CODE_W-1:0]       mag_x, mag_y;
    logic signed [XS_W-1:0]  xs_reg, ys_reg, xs2_reg, ys2_reg;
    logic [SCALE_W-1:0]      scale_reg, scale2_reg;
    logic                    ok_reg, ok2_reg, go_reg, go2_reg;
    logic [XSQ_W-1:0]        xsq_reg, ysq_reg;
    logic signed [LHS_W-1:0] lhs;
    logic                    hit;
    res_t                    res_next, res_reg;

    always_comb begin
        rnd_x = {1'b0, in_data.quo_x} + (QUO_W+1)'(1);
        rnd_y = {1'b0, in_data.quo_y} + (QUO_W+1)'(1);
        mag_x = rnd_x[QUO_W:1];
        mag_y = rnd_y[QUO_W:1];
    end

    always_comb begin
        lhs = LHS_W'(xsq_reg) + LHS_W'(ysq_reg)
              - (LHS_W'(xs2_reg) <<< CODE_FRAC_BITS)
              - (LHS_W'(ys2_reg) <<< CODE_FRAC_BITS);
        hit = go2_reg && (lhs <= $signed(LHS_W'(bound)));
        res_next.scale      = scale2_reg;
        res_next.scale_pass = ok2_reg;
        res_next.in_circle  = hit;
        res_next.code_x     = hit ? xs2_reg[CODE_W-1:0] : '0;
        res_next.code_y     = hit ? ys2_reg[CODE_W-1:0] : '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[1:0], in_vld};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            xs_reg     <= in_data.neg_x ? -$signed({1'b0, mag_x}) : $signed({1'b0, mag_x});
            ys_reg     <= in_data.neg_y ? -$signed({1'b0, mag_y}) : $signed({1'b0, mag_y});
            scale_reg  <= in_data.scale;
            ok_reg     <= in_data.ok;
            go_reg     <= in_data.go;
            xsq_reg    <= XSQ_W'(xs_reg) * XSQ_W'(xs_reg);
            ysq_reg    <= XSQ_W'(ys_reg) * XSQ_W'(ys_reg);
            xs2_reg    <= xs_reg;
            ys2_reg    <= ys_reg;
            scale2_reg <= scale_reg;
            ok2_reg    <= ok_reg;
            go2_reg    <= go_reg;
            res_reg    <= res_next;
        end
    end

    assign out_vld  = vld_reg[2];
    assign out_data = res_reg;

endmodule

@@ sv/quad_code_frame_and_circle_test_unit.sv @@
// Top level of the quad code frame and circle test: config, divider row, handshake.
//
//  Channel   Direction  Handshake         Payload
//  s_        in         tvalid / tready   tdata: a_x a_y b_x b_y c_x c_y
//  m_        out        tvalid / tready   tdata: scale_sq code_x code_y; tuser: flags
//  cfg_      in         cfg_wr_en         cfg_index, cfg_wdata
//
// One beat is taken every cycle while the output side keeps up. An input beat
// passes through 4 front stages, 21 divider cells of one quotient bit each and
// 3 back stages on its way to the result beat.
// Reset is synchronous and active low; it empties the pipeline and restores the
// configuration defaults. The whole pipeline advances only when the output
// register is empty or being read, so a stalled result holds every stage.
`include "quad_code_frame_and_circle_test_unit_defines.svh"
module quad_code_frame_and_circle_test_unit (
    input  logic                              aclk,
    input  logic                              aresetn,
    // a_x, a_y, b_x, b_y, c_x, c_y, 24 bits each, from the lowest bit up.
    input  logic [qcf_pkg::IN_TDATA_W-1:0]    s_tdata,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // scale_sq (49), code_x (21), code_y (21), then zero fill, lowest bit up.
    output logic [qcf_pkg::OUT_TDATA_W-1:0]   m_tdata,
    // scale pass flag, in_circle, lowest bit up.
    output logic [qcf_pkg::OUT_TUSER_W-1:0]   m_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    input  logic                              cfg_wr_en,
    input  logic [qcf_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [qcf_pkg::CFG_W-1:0]         cfg_wdata
);
    import qcf_pkg::*;

    localparam int NCELL = QUO_W;

    logic [SCALE_W-1:0] min_scale_reg, max_scale_reg;
    logic [TOL_W-1:0]   tol_reg;
    logic [RHS_W-1:0]   rhs;
    logic [RHSQ_W-1:0]  bound_reg;
    logic               en;

    logic               row_vld [NCELL+1];
    div_t               row_data [NCELL+1];
    logic               res_vld;
    res_t               res;

    // Configuration registers are plain writes; an index past the list is ignored.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_scale_reg <= '0;
            max_scale_reg <= MAX_SCALE_RESET;
            tol_reg       <= TOL_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_MIN_SCALE: min_scale_reg <= cfg_wdata;
                REG_MAX_SCALE: max_scale_reg <= cfg_wdata;
                REG_CODE_TOL:  tol_reg       <= cfg_wdata[TOL_W-1:0];
                default: ;
            endcase
        end
    end

    // Circle bound t*(sqrt2 + t) in units of 2^-46, brought down to the code
    // scale squared. Flooring is exact here because the left side is an integer.
    always_comb begin
        rhs = RHS_W'(tol_reg) * RHS_W'(SQRT2_Q30 + (BSUM_W'(tol_reg) << TOL_ALIGN));
    end

    always_ff @(posedge aclk) begin
        bound_reg <= RHSQ_W'(rhs >> BOUND_SHIFT);
    end

    // The output register is the last back-end stage; everything moves together.
    assign en       = !res_vld || m_tready;
    assign s_tready = en;

    qcf_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .en           (en),
        .in_vld       (s_tvalid),
        .a_x          (s_tdata[0*COORD_W +: COORD_W]),
        .a_y          (s_tdata[1*COORD_W +: COORD_W]),
        .b_x          (s_tdata[2*COORD_W +: COORD_W]),
        .b_y          (s_tdata[3*COORD_W +: COORD_W]),
        .c_x          (s_tdata[4*COORD_W +: COORD_W]),
        .c_y          (s_tdata[5*COORD_W +: COORD_W]),
        .min_scale_sq (min_scale_reg),
        .max_scale_sq (max_scale_reg),
        .out_vld      (row_vld[0]),
        .out_data     (row_data[0])
    );

    // Row of divider cells: four integer quotient bits, then the fraction and
    // one extra bit for rounding.
    for (genvar i = 0; i < NCELL; i++) begin : g_cell
        qcf_div_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .en       (en),
            .in_vld   (row_vld[i]),
            .in_data  (row_data[i]),
            .out_vld  (row_vld[i+1]),
            .out_data (row_data[i+1])
        );
    end

    qcf_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_vld   (row_vld[NCELL]),
        .in_data  (row_data[NCELL]),
        .bound    (bound_reg),
        .out_vld  (res_vld),
        .out_data (res)
    );

    assign m_tvalid = res_vld;
    assign m_tdata  = OUT_TDATA_W'({res.code_y, res.code_x, res.scale});
    assign m_tuser  = {res.in_circle, res.scale_pass};

    `QCF_ASSERT_NOW(a_circle_needs_scale, m_tvalid && res.in_circle, res.scale_pass, "in_circle without scale pass")
    `QCF_ASSERT_NOW(a_zero_code_outside, m_tvalid && !res.in_circle, res.code_x == '0 && res.code_y == '0, "code not zero outside circle")
    `QCF_ASSERT_NOW(a_scale_nonzero, m_tvalid && res.scale_pass, res.scale != '0, "zero scale accepted")
    `QCF_ASSERT_NEXT(a_pipe_holds, m_tvalid && !m_tready, $stable(row_data[NCELL]), "pipeline moved under stall")

endmodule
